/* rtl/core/scpw_pkg.sv */
// Package for the scan point covariance weight block.
// Holds the transaction, configuration and queue entry types and shared constants.
// Depends on nothing.
`default_nettype none

package scpw_pkg;

  typedef struct packed {
    logic              on_line;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } in_t;

  typedef struct packed {
    logic [16:0] weight;
    logic        used_default;
  } out_t;

  typedef struct packed {
    logic [31:0] var_x;
    logic [31:0] var_y;
    logic [31:0] cov_xy;
  } cfg_t;

  typedef struct packed {
    logic               dflt;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } cls_t;

  typedef enum logic [1:0] {
    CFG_VAR_X  = 2'd0,
    CFG_VAR_Y  = 2'd1,
    CFG_COV_XY = 2'd2
  } cfg_idx_e;

  localparam logic [31:0] VAR_RESET = 32'd65536;
  localparam logic [31:0] COV_RESET = 32'd0;
  localparam logic [16:0] W_ONE     = 17'd65536;
  localparam logic [16:0] W_DEFAULT = 17'd32768;
  localparam logic [8:0]  MIN_LEN2  = 9'd100;
  localparam int unsigned Q30       = 30;

endpackage

`default_nettype wire

/* rtl/core/scpw_front.sv */
// Front end: accepts transactions and classifies them as default or computed.
// Forms the line deltas. Depends on scpw_pkg.
`default_nettype none

module scpw_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire scpw_pkg::in_t  item_i,
  input  wire scpw_pkg::cfg_t cfg_i,
  input  wire logic           full_i,
  output logic                push_o,
  output scpw_pkg::cls_t      cls_o
);
  import scpw_pkg::*;

  logic               vld_q, vld_d;
  cls_t               cls_q, cls_d;
  logic               accept;
  logic signed [16:0] dx, dy;
  logic [16:0]        ax, ay;
  logic [8:0]         sq_sum;
  logic               short_line, zero_trace;

  assign push_o = vld_q & ~full_i;
  assign busy_o = vld_q & full_i;
  assign accept = start_i & ~busy_o;
  assign cls_o  = cls_q;

  always_comb begin
    dx = 17'(item_i.end_x) - 17'(item_i.start_x);
    dy = 17'(item_i.end_y) - 17'(item_i.start_y);
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    sq_sum = 9'(ax[3:0]) * 9'(ax[3:0]) + 9'(ay[3:0]) * 9'(ay[3:0]);
    short_line = (ax <= 17'd10) && (ay <= 17'd10) && (sq_sum <= MIN_LEN2);
    zero_trace = (cfg_i.var_x == 32'd0) && (cfg_i.var_y == 32'd0);
    cls_d.dflt = ~item_i.on_line | short_line | zero_trace;
    cls_d.dx   = dx;
    cls_d.dy   = dy;
  end

  assign vld_d = accept | (vld_q & ~push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/scpw_fifo.sv */
// Two-entry queue between the front end and the arithmetic back end.
// Depends on scpw_pkg.
`default_nettype none

module scpw_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire scpw_pkg::cls_t data_i,
  output logic                full_o,
  output logic                valid_o,
  output scpw_pkg::cls_t      data_o
);
  import scpw_pkg::*;

  cls_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("Queue written while full.");

endmodule

`default_nettype wire

/* rtl/core/scpw_back.sv */
// Back end: pipelined fixed-point weight computation, one transaction per cycle.
// Uses bit-per-stage square root and restoring division pipelines. Depends on scpw_pkg.
`default_nettype none

module scpw_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire scpw_pkg::cls_t cls_i,
  input  wire scpw_pkg::cfg_t cfg_i,
  output logic                done_o,
  output scpw_pkg::out_t      result_o
);
  import scpw_pkg::*;

  localparam int XS         = 32;
  localparam int QB         = 31;
  localparam int SS         = 31;
  localparam int TB         = 18;
  localparam int BACK_DEPTH = 1 + (XS + 1) + 1 + (QB + 1) + 2 + (SS + 1) + 1 + (TB + 1) + 1;

  typedef struct packed {
    logic               dflt;
    logic [32:0]        mag_c;
    logic               c_neg;
    logic [33:0]        mag_s;
    logic               s_neg;
    logic [33:0]        l2;
    logic signed [32:0] p;
    logic signed [32:0] q;
    logic [31:0]        hmp;
    logic [31:0]        hmq;
    logic [32:0]        trace;
  } b0_t;

  typedef struct packed {
    logic               dflt;
    logic [63:0]        sx;
    logic [63:0]        sr;
    logic [63:0]        c_rem;
    logic [30:0]        c_q;
    logic               c_neg;
    logic [63:0]        s_rem;
    logic [30:0]        s_q;
    logic               s_neg;
    logic [33:0]        l2;
    logic signed [32:0] p;
    logic signed [32:0] q;
    logic [31:0]        hmp;
    logic [31:0]        hmq;
    logic [32:0]        trace;
  } x_t;

  typedef struct packed {
    logic               dflt;
    logic signed [63:0] pc;
    logic signed [63:0] ps;
    logic signed [31:0] c2f;
    logic signed [31:0] s2f;
    logic [31:0]        d;
    logic [31:0]        hmp;
    logic [31:0]        hmq;
    logic               pneg;
    logic               qneg;
    logic [32:0]        trace;
  } m1_t;

  typedef struct packed {
    logic               dflt;
    logic signed [63:0] n;
    logic signed [31:0] c2f;
    logic signed [31:0] s2f;
    logic [31:0]        d;
    logic [63:0]        ct_rem;
    logic [30:0]        ct_q;
    logic [63:0]        st_rem;
    logic [30:0]        st_q;
    logic               pneg;
    logic               qneg;
    logic [32:0]        trace;
  } y_t;

  typedef struct packed {
    logic               dflt;
    logic signed [63:0] n;
    logic signed [31:0] c2f;
    logic signed [31:0] s2f;
    logic signed [31:0] c2t;
    logic signed [31:0] s2t;
    logic [32:0]        trace;
  } z1_t;

  typedef struct packed {
    logic               dflt;
    logic signed [63:0] n;
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic [32:0]        trace;
  } z2_t;

  typedef struct packed {
    logic               dflt;
    logic [63:0]        sx;
    logic [63:0]        sr;
    logic signed [63:0] n;
    logic [32:0]        trace;
  } s_t;

  typedef struct packed {
    logic        dflt;
    logic [48:0] den;
    logic [15:0] sh;
    logic        nneg;
    logic [63:0] nmag;
  } z4_t;

  typedef struct packed {
    logic        dflt;
    logic        sat;
    logic        nneg;
    logic [15:0] sh;
    logic [48:0] den;
    logic [67:0] rem;
    logic [17:0] tq;
  } dv_t;

  logic [BACK_DEPTH-1:0] vld_q;
  b0_t  b0_q, b0_d;
  x_t   x_q [XS+1];
  x_t   x0_d;
  m1_t  m1_q, m1_d;
  y_t   y_q [QB+1];
  y_t   y0_d;
  z1_t  z1_q, z1_d;
  z2_t  z2_q, z2_d;
  s_t   s_q [SS+1];
  s_t   s0_d;
  z4_t  z4_q, z4_d;
  dv_t  dv_q [TB+1];
  dv_t  dv0_d;
  out_t result_q, result_d;

  // Entry stage: line products and covariance terms.
  logic signed [35:0] dxe, dye, sqx, sqy, pxy, numc, nums;
  logic signed [32:0] pv, qv;
  logic [32:0]        mp, mq;
  logic               half;

  always_comb begin
    dxe  = 36'(cls_i.dx);
    dye  = 36'(cls_i.dy);
    sqx  = dxe * dxe;
    sqy  = dye * dye;
    pxy  = dxe * dye;
    numc = sqx - sqy;
    nums = pxy + pxy;
    pv   = $signed({1'b0, cfg_i.var_x}) - $signed({1'b0, cfg_i.var_y});
    qv   = $signed({cfg_i.cov_xy, 1'b0});
    mp   = pv[32] ? 33'(-pv) : 33'(pv);
    mq   = qv[32] ? 33'(-qv) : 33'(qv);
    half = mp[32] | mp[31] | mq[32] | mq[31];
    b0_d.dflt  = cls_i.dflt;
    b0_d.c_neg = numc[35];
    b0_d.mag_c = numc[35] ? 33'(-numc) : 33'(numc);
    b0_d.s_neg = nums[35];
    b0_d.mag_s = nums[35] ? 34'(-nums) : 34'(nums);
    b0_d.l2    = 34'(sqx + sqy);
    b0_d.p     = pv;
    b0_d.q     = qv;
    b0_d.hmp   = half ? mp[32:1] : mp[31:0];
    b0_d.hmq   = half ? mq[32:1] : mq[31:0];
    b0_d.trace = {1'b0, cfg_i.var_x} + {1'b0, cfg_i.var_y};
  end

  always_comb begin
    x0_d       = '0;
    x0_d.dflt  = b0_q.dflt;
    x0_d.sx    = 64'(b0_q.hmp) * 64'(b0_q.hmp) + 64'(b0_q.hmq) * 64'(b0_q.hmq);
    x0_d.sr    = 64'd0;
    x0_d.c_rem = 64'(b0_q.mag_c) << Q30;
    x0_d.c_neg = b0_q.c_neg;
    x0_d.s_rem = 64'(b0_q.mag_s) << Q30;
    x0_d.s_neg = b0_q.s_neg;
    x0_d.l2    = b0_q.l2;
    x0_d.p     = b0_q.p;
    x0_d.q     = b0_q.q;
    x0_d.hmp   = b0_q.hmp;
    x0_d.hmq   = b0_q.hmq;
    x0_d.trace = b0_q.trace;
  end

  // Eigenvalue spread square root alongside the line angle divisions.
  for (genvar k = 0; k < XS; k++) begin : g_x
    localparam int SB = 62 - 2 * k;
    localparam int DI = (k < QB) ? QB - 1 - k : 0;
    x_t          x_d;
    logic [63:0] sbit, stry, dsh;
    always_comb begin
      x_d  = x_q[k];
      sbit = 64'd1 << SB;
      stry = x_q[k].sr + sbit;
      dsh  = 64'(x_q[k].l2) << DI;
      if (x_q[k].sx >= stry) begin
        x_d.sx = x_q[k].sx - stry;
        x_d.sr = (x_q[k].sr >> 1) + sbit;
      end else begin
        x_d.sr = x_q[k].sr >> 1;
      end
      if (k < QB) begin
        if (x_q[k].c_rem >= dsh) begin
          x_d.c_rem    = x_q[k].c_rem - dsh;
          x_d.c_q[DI]  = 1'b1;
        end
        if (x_q[k].s_rem >= dsh) begin
          x_d.s_rem    = x_q[k].s_rem - dsh;
          x_d.s_q[DI]  = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      x_q[k+1] <= x_d;
    end
  end

  logic signed [31:0] c2f, s2f;

  always_comb begin
    c2f = $signed({1'b0, x_q[XS].c_q});
    if (x_q[XS].c_neg) begin
      c2f = -c2f;
    end
    s2f = $signed({1'b0, x_q[XS].s_q});
    if (x_q[XS].s_neg) begin
      s2f = -s2f;
    end
    m1_d.dflt  = x_q[XS].dflt;
    m1_d.pc    = 64'(c2f) * 64'($signed(x_q[XS].p));
    m1_d.ps    = 64'(s2f) * 64'($signed(x_q[XS].q));
    m1_d.c2f   = c2f;
    m1_d.s2f   = s2f;
    m1_d.d     = x_q[XS].sr[31:0];
    m1_d.hmp   = x_q[XS].hmp;
    m1_d.hmq   = x_q[XS].hmq;
    m1_d.pneg  = x_q[XS].p[32];
    m1_d.qneg  = x_q[XS].q[32];
    m1_d.trace = x_q[XS].trace;
  end

  always_comb begin
    y0_d        = '0;
    y0_d.dflt   = m1_q.dflt;
    y0_d.n      = $signed(m1_q.pc) + $signed(m1_q.ps);
    y0_d.c2f    = m1_q.c2f;
    y0_d.s2f    = m1_q.s2f;
    y0_d.d      = m1_q.d;
    y0_d.ct_rem = 64'(m1_q.hmp) << Q30;
    y0_d.st_rem = 64'(m1_q.hmq) << Q30;
    y0_d.pneg   = m1_q.pneg;
    y0_d.qneg   = m1_q.qneg;
    y0_d.trace  = m1_q.trace;
  end

  // Eigenvector angle divisions.
  for (genvar k = 0; k < QB; k++) begin : g_y
    localparam int DI = QB - 1 - k;
    y_t          y_d;
    logic [63:0] dsh;
    always_comb begin
      y_d = y_q[k];
      dsh = 64'(y_q[k].d) << DI;
      if (y_q[k].ct_rem >= dsh) begin
        y_d.ct_rem   = y_q[k].ct_rem - dsh;
        y_d.ct_q[DI] = 1'b1;
      end
      if (y_q[k].st_rem >= dsh) begin
        y_d.st_rem   = y_q[k].st_rem - dsh;
        y_d.st_q[DI] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      y_q[k+1] <= y_d;
    end
  end

  logic signed [31:0] c2t, s2t;

  always_comb begin
    c2t = $signed({1'b0, y_q[QB].ct_q});
    if (y_q[QB].pneg) begin
      c2t = -c2t;
    end
    s2t = $signed({1'b0, y_q[QB].st_q});
    if (y_q[QB].qneg) begin
      s2t = -s2t;
    end
    if (y_q[QB].d == 32'd0) begin
      c2t = 32'sd1 <<< Q30;
      s2t = 32'sd0;
    end
    z1_d.dflt  = y_q[QB].dflt;
    z1_d.n     = y_q[QB].n;
    z1_d.c2f   = y_q[QB].c2f;
    z1_d.s2f   = y_q[QB].s2f;
    z1_d.c2t   = c2t;
    z1_d.s2t   = s2t;
    z1_d.trace = y_q[QB].trace;
  end

  always_comb begin
    z2_d.dflt  = z1_q.dflt;
    z2_d.n     = z1_q.n;
    z2_d.pa    = 64'($signed(z1_q.s2f)) * 64'($signed(z1_q.c2t));
    z2_d.pb    = 64'($signed(z1_q.c2f)) * 64'($signed(z1_q.s2t));
    z2_d.trace = z1_q.trace;
  end

  logic signed [63:0] diff;
  logic [63:0]        mdiff, aval;

  always_comb begin
    diff  = $signed(z2_q.pa) - $signed(z2_q.pb);
    mdiff = diff[63] ? 64'(-diff) : 64'(diff);
    aval  = mdiff >> Q30;
    if (aval > (64'd1 << Q30)) begin
      aval = 64'd1 << Q30;
    end
    s0_d.dflt  = z2_q.dflt;
    s0_d.sx    = ((64'd1 << Q30) + aval) << Q30;
    s0_d.sr    = 64'd0;
    s0_d.n     = z2_q.n;
    s0_d.trace = z2_q.trace;
  end

  // Square root giving the sum of the absolute direction cosines.
  for (genvar k = 0; k < SS; k++) begin : g_s
    localparam int SB = 60 - 2 * k;
    s_t          s_d;
    logic [63:0] sbit, stry;
    always_comb begin
      s_d  = s_q[k];
      sbit = 64'd1 << SB;
      stry = s_q[k].sr + sbit;
      if (s_q[k].sx >= stry) begin
        s_d.sx = s_q[k].sx - stry;
        s_d.sr = (s_q[k].sr >> 1) + sbit;
      end else begin
        s_d.sr = s_q[k].sr >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      s_q[k+1] <= s_d;
    end
  end

  logic [30:0] sval;
  logic [63:0] dprod;

  always_comb begin
    sval       = s_q[SS].sr[30:0];
    dprod      = 64'(s_q[SS].trace) * 64'(sval);
    z4_d.dflt  = s_q[SS].dflt;
    z4_d.den   = dprod[63:15];
    z4_d.sh    = sval[30:15];
    z4_d.nneg  = s_q[SS].n[63];
    z4_d.nmag  = s_q[SS].n[63] ? 64'(-s_q[SS].n) : 64'(s_q[SS].n);
  end

  always_comb begin
    dv0_d.dflt = z4_q.dflt;
    dv0_d.sat  = {4'd0, z4_q.nmag} >= ({19'd0, z4_q.den} << TB);
    dv0_d.nneg = z4_q.nneg;
    dv0_d.sh   = z4_q.sh;
    dv0_d.den  = z4_q.den;
    dv0_d.rem  = {4'd0, z4_q.nmag};
    dv0_d.tq   = '0;
  end

  // Correction term division.
  for (genvar k = 0; k < TB; k++) begin : g_dv
    localparam int DI = TB - 1 - k;
    dv_t         dv_d;
    logic [67:0] dsh;
    always_comb begin
      dv_d = dv_q[k];
      dsh  = {19'd0, dv_q[k].den} << DI;
      if (dv_q[k].rem >= dsh) begin
        dv_d.rem    = dv_q[k].rem - dsh;
        dv_d.tq[DI] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      dv_q[k+1] <= dv_d;
    end
  end

  logic signed [20:0] t21, w21;

  always_comb begin
    t21 = $signed({3'd0, dv_q[TB].tq});
    if (dv_q[TB].nneg) begin
      t21 = -t21;
    end
    w21 = 21'sd65536 - $signed({5'd0, dv_q[TB].sh}) - t21;
    result_d.used_default = 1'b0;
    if (dv_q[TB].dflt) begin
      result_d.weight       = W_DEFAULT;
      result_d.used_default = 1'b1;
    end else if (dv_q[TB].sat) begin
      result_d.weight = dv_q[TB].nneg ? W_ONE : 17'd0;
    end else if (w21 < 21'sd0) begin
      result_d.weight = 17'd0;
    end else if (w21 > 21'sd65536) begin
      result_d.weight = W_ONE;
    end else begin
      result_d.weight = w21[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[BACK_DEPTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q     <= b0_d;
    x_q[0]   <= x0_d;
    m1_q     <= m1_d;
    y_q[0]   <= y0_d;
    z1_q     <= z1_d;
    z2_q     <= z2_d;
    s_q[0]   <= s0_d;
    z4_q     <= z4_d;
    dv_q[0]  <= dv0_d;
    result_q <= result_d;
  end

  assign done_o   = vld_q[BACK_DEPTH-1];
  assign result_o = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##BACK_DEPTH done_o)
    else $error("Transaction did not complete at the pipeline depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_q.weight <= W_ONE))
    else $error("Weight above one.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_q.used_default) |-> (result_q.weight == W_DEFAULT))
    else $error("Default flag set with a computed weight.");

endmodule

`default_nettype wire

/* rtl/core/scan_point_covariance_weight.sv */
// Top level of the scan point covariance weight block.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on scpw_pkg, scpw_front, scpw_fifo and scpw_back.
//
// Usage: a transaction is accepted at a rising edge with start_i high and
// busy_o low; item_i carries the on_line flag and the line endpoints in mm.
// The configuration registers (x variance, y variance, x-y covariance) are
// written through cfg_we_i, cfg_idx_i and cfg_data_i while no transaction is
// in flight; reset loads unit variances and zero covariance.
// Each result appears on result_o for one cycle with done_o high, in the order
// in which the transactions were accepted. One transaction is accepted every
// cycle while busy_o is low; each passes through the bit-per-stage square root
// and division pipelines of the back end. The receiver cannot stall, so busy_o
// stays low in normal use. Reset empties the pipeline and the queue;
// transactions in flight are dropped.
`default_nettype none

module scan_point_covariance_weight (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire scpw_pkg::in_t  item_i,
  output logic                done_o,
  output scpw_pkg::out_t      result_o,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [31:0]    cfg_data_i
);
  import scpw_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push, full, q_valid;
  cls_t cls_front, cls_queue;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VAR_X:  cfg_d.var_x  = cfg_data_i;
        CFG_VAR_Y:  cfg_d.var_y  = cfg_data_i;
        CFG_COV_XY: cfg_d.cov_xy = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.var_x  <= VAR_RESET;
      cfg_q.var_y  <= VAR_RESET;
      cfg_q.cov_xy <= COV_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  scpw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .cls_o   (cls_front)
  );

  scpw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_front),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (cls_queue)
  );

  scpw_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .cls_i    (cls_queue),
    .cfg_i    (cfg_q),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for scan_point_covariance_weight.
// Drives directed and random transactions under several covariance settings and
// checks every result against a fixed-point predictor; depends on scpw_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import scpw_pkg::*;

  localparam int LATENCY = 124;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct {
    in_t  item;
    bit   known;
    out_t want;
  } vector_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  in_t         item_i;
  logic        done_o;
  out_t        result_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  logic [31:0] vx_model;
  logic [31:0] vy_model;
  logic [31:0] cov_model;
  out_t        weight_queue[$];
  int          fail_count;
  int          idle_cycles;
  int          results_seen;
  bit          allow_idle;

  scan_point_covariance_weight uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint scale_q30(longint num, logic [63:0] den);
    logic [63:0] m;
    logic [63:0] r;
    m = (num < 0) ? -num : num;
    r = (m << 30) / den;
    return (num < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic out_t predict_weight(in_t it, logic [31:0] vx, logic [31:0] vy,
                                          logic [31:0] cov);
    out_t        o;
    longint      dx, dy, len2, c2f, s2f, p, q, c2t, s2t, sa, n, t, w;
    logic [63:0] tr, mp, mq, d, a, s, den, tq;
    dx = longint'(it.end_x) - longint'(it.start_x);
    dy = longint'(it.end_y) - longint'(it.start_y);
    len2 = dx * dx + dy * dy;
    tr = 64'(vx) + 64'(vy);
    if (!it.on_line || len2 <= longint'(MIN_LEN2) || tr == 0) begin
      o.weight = W_DEFAULT;
      o.used_default = 1'b1;
      return o;
    end
    c2f = scale_q30(dx * dx - dy * dy, len2);
    s2f = scale_q30(2 * dx * dy, len2);
    p = longint'(64'(vx)) - longint'(64'(vy));
    q = 2 * longint'($signed(cov));
    mp = (p < 0) ? -p : p;
    mq = (q < 0) ? -q : q;
    if (mp >= (64'd1 << 31) || mq >= (64'd1 << 31)) begin
      mp = mp >> 1;
      mq = mq >> 1;
    end
    d = isqrt(mp * mp + mq * mq);
    c2t = longint'(1) << 30;
    s2t = 0;
    if (d != 0) begin
      c2t = scale_q30((p < 0) ? -longint'(mp) : longint'(mp), d);
      s2t = scale_q30((q < 0) ? -longint'(mq) : longint'(mq), d);
    end
    sa = (s2f * c2t - c2f * s2t) / (longint'(1) << 30);
    a = (sa < 0) ? -sa : sa;
    if (a > (64'd1 << 30)) a = 64'd1 << 30;
    s = isqrt(((64'd1 << 30) + a) << 30);
    n = c2f * p + s2f * q;
    den = (tr * s) >> 15;
    tq = ((n < 0) ? 64'(-n) : 64'(n)) / den;
    if (tq > (64'd1 << 40)) tq = 64'd1 << 40;
    t = (n < 0) ? -longint'(tq) : longint'(tq);
    w = 65536 - longint'(s >> 15) - t;
    if (w < 0) w = 0;
    if (w > 65536) w = 65536;
    o.weight = w[16:0];
    o.used_default = 1'b0;
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_VAR_X:  vx_model <= cfg_data_i;
          CFG_VAR_Y:  vy_model <= cfg_data_i;
          CFG_COV_XY: cov_model <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) weight_queue.push_back(predict_weight(item_i, vx_model, vy_model,
                                                                    cov_model));
      if (done_o) begin
        results_seen++;
        if (weight_queue.size() == 0) begin
          $error("unexpected transaction: weight %0d used_default %0b",
                 result_o.weight, result_o.used_default);
          fail_count++;
        end else begin
          out_t want;
          want = weight_queue.pop_front();
          if (result_o.weight !== want.weight) begin
            $error("weight: expected %0d, actual %0d", want.weight, result_o.weight);
            fail_count++;
          end
          if (result_o.used_default !== want.used_default) begin
            $error("used_default: expected %0b, actual %0b", want.used_default,
                   result_o.used_default);
            fail_count++;
          end
        end
      end
      if ((start_i && !busy_o) || done_o || cfg_we_i) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_item(in_t it);
    logic b;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    forever begin
      @(negedge clk_i);
      b = busy_o;
      @(posedge clk_i);
      if (!b) break;
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (weight_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [31:0] vx, logic [31:0] vy, logic [31:0] cov);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_VAR_X;
    cfg_data_i <= vx;
    @(posedge clk_i);
    cfg_idx_i <= CFG_VAR_Y;
    cfg_data_i <= vy;
    @(posedge clk_i);
    cfg_idx_i <= CFG_COV_XY;
    cfg_data_i <= cov;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_t make_line(bit on, int sx, int sy, int ex, int ey);
    in_t it;
    it.on_line = on;
    it.start_x = sx[15:0];
    it.start_y = sy[15:0];
    it.end_x = ex[15:0];
    it.end_y = ey[15:0];
    return it;
  endfunction

  function automatic in_t random_line();
    in_t         it;
    int          span;
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    it = in_t'(raw[$bits(in_t)-1:0]);
    it.on_line = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 3))
      0: span = 12;
      1: span = 300;
      2: span = 5000;
      default: span = 0;
    endcase
    if (span != 0) begin
      it.end_x = it.start_x + 16'($urandom_range(0, 2 * span) - span);
      it.end_y = it.start_y + 16'($urandom_range(0, 2 * span) - span);
    end
    return it;
  endfunction

  function automatic logic [31:0] random_var();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 1 << 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] random_cov();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      default: return $urandom();
    endcase
  endfunction

  vector_t directed[$];

  initial begin
    logic [31:0] vx, vy, cov;
    out_t        got_default;
    out_t        half_weight;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_VAR_X;
    cfg_data_i = '0;
    vx_model = VAR_RESET;
    vy_model = VAR_RESET;
    cov_model = COV_RESET;
    fail_count = 0;
    idle_cycles = 0;
    results_seen = 0;
    allow_idle = 1'b1;
    got_default = '{weight: W_DEFAULT, used_default: 1'b1};
    half_weight = '{weight: W_DEFAULT, used_default: 1'b0};

    directed.push_back('{make_line(0, 0, 0, 1000, 0), 1, got_default});
    directed.push_back('{make_line(1, 0, 0, 1000, 0), 1, half_weight});
    directed.push_back('{make_line(1, 0, 0, 0, -1000), 1, half_weight});
    directed.push_back('{make_line(1, 5, 5, 15, 5), 1, got_default});
    directed.push_back('{make_line(1, 5, 5, 5, 5), 1, got_default});
    directed.push_back('{make_line(1, 0, 0, 10, 1), 0, half_weight});
    directed.push_back('{make_line(1, 0, 0, 1000, 1000), 0, half_weight});
    directed.push_back('{make_line(1, -32768, -32768, 32767, 32767), 0, half_weight});
    directed.push_back('{make_line(1, 32767, -32768, -32768, 32767), 0, half_weight});
    directed.push_back('{make_line(1, -32768, 0, 32767, 0), 1, half_weight});
    directed.push_back('{make_line(0, -32768, -32768, 32767, 32767), 1, got_default});
    directed.push_back('{make_line(1, 100, -200, 300, 700), 0, half_weight});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_item(directed[i].item);
      if (directed[i].known &&
          predict_weight(directed[i].item, vx_model, vy_model, cov_model)
          !== directed[i].want) begin
        $error("directed row %0d: predictor disagrees with expected table entry", i);
        fail_count++;
      end
    end

    write_config(32'd0, 32'd0, 32'd0);
    send_item(make_line(1, 0, 0, 1000, 300));
    send_item(make_line(1, -32768, -32768, 32767, 32767));
    write_config(32'hFFFF_FFFF, 32'd0, 32'h8000_0000);
    send_item(make_line(1, 0, 0, 1000, 300));
    send_item(make_line(1, -32768, 32767, 32767, -32768));
    write_config(32'd1000, 32'd1000, 32'h7FFF_FFFF);
    send_item(make_line(1, 0, 0, 1000, 1000));
    send_item(make_line(1, 0, 0, -1000, 1000));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      vx = random_var();
      vy = random_var();
      cov = random_cov();
      write_config(vx, vy, cov);
      allow_idle = (ph < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_item(random_line());
    end

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Checked %0d results over directed lines and %0d random covariance settings,",
             results_seen, NUM_PHASES);
    $display("including zero trace, isotropic, saturated and non-PSD covariances.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/scpw_pkg.sv
rtl/core/scpw_front.sv
rtl/core/scpw_fifo.sv
rtl/core/scpw_back.sv
rtl/core/scan_point_covariance_weight.sv
tb/sv/tb_top.sv
